// ===== design/kbr_pkg.sv =====
// shared types and constants of the k-line block receiver
package kbr_pkg;

	localparam int unsigned TimeoutW = 10;
	localparam int unsigned ApbAddrW = 4;
	localparam int unsigned ApbDataW = 32;

	// input function codes
	typedef enum logic [1:0] {
		FUNC_RX_BYTE   = 2'd0,
		FUNC_TICK      = 2'd1,
		FUNC_START_KW  = 2'd2,
		FUNC_START_BLK = 2'd3
	} kbr_func_t;

	// reported events
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_KW_OK   = 3'd1,
		EV_BLK_OK  = 3'd2,
		EV_KW_BAD  = 3'd3,
		EV_ECHO    = 3'd4,
		EV_TIMEOUT = 3'd5,
		EV_LENGTH  = 3'd6,
		EV_END     = 3'd7
	} kbr_event_t;

	// register indexes
	typedef enum logic [1:0] {
		REG_KW_TIMEOUT   = 2'd0,
		REG_ECHO_TIMEOUT = 2'd1,
		REG_LEN_TIMEOUT  = 2'd2,
		REG_BYTE_TIMEOUT = 2'd3
	} kbr_reg_t;

	localparam logic [TimeoutW-1:0] KwTimeoutRst   = 10'd200;
	localparam logic [TimeoutW-1:0] EchoTimeoutRst = 10'd200;
	localparam logic [TimeoutW-1:0] LenTimeoutRst  = 10'd100;
	localparam logic [TimeoutW-1:0] ByteTimeoutRst = 10'd20;

	localparam logic [7:0] KwByte0     = 8'h55;
	localparam logic [7:0] KwByte1     = 8'h01;
	localparam logic [7:0] KwByte2     = 8'h8A;
	localparam logic [7:0] KwAnswer    = 8'h75;
	localparam logic [7:0] EndByte     = 8'h03;
	localparam logic [7:0] ComplMask   = 8'hFF;
	localparam logic [7:0] KwCount     = 8'd3;
	localparam logic [7:0] MinBlockLen = 8'd3;

	typedef struct packed {
		logic [TimeoutW-1:0] kw_timeout;
		logic [TimeoutW-1:0] echo_timeout;
		logic [TimeoutW-1:0] len_timeout;
		logic [TimeoutW-1:0] byte_timeout;
	} kbr_cfg_t;

	typedef struct packed {
		logic       present;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       data_valid;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		kbr_event_t event_res;
	} kbr_res_t;

	function automatic logic [7:0] kw_expected(input logic [1:0] pos);
		case (pos)
			2'd0: kw_expected = KwByte0;
			2'd1: kw_expected = KwByte1;
			2'd2: kw_expected = KwByte2;
			default: kw_expected = KwByte0;
		endcase
	endfunction

endpackage

// ===== design/kbr_if.sv =====
// valid/ready channel interfaces for events in and results out
interface kbr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] rx_byte;

	modport source(output valid, output func, output rx_byte, input ready);
	modport sink(input valid, input func, input rx_byte, output ready);
endinterface

interface kbr_out_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       data_valid;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic [2:0] event_res;

	modport source(output valid, output tx_valid, output tx_byte, output data_valid,
		output data_byte, output byte_index, output event_res, input ready);
	modport sink(input valid, input tx_valid, input tx_byte, input data_valid,
		input data_byte, input byte_index, input event_res, output ready);
endinterface

// ===== design/kbr_regs.sv =====
// apb register file holding the four timeout settings
module kbr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kbr_pkg::ApbAddrW-1:0]  paddr,
	input  logic [kbr_pkg::ApbDataW-1:0]  pwdata,
	output logic [kbr_pkg::ApbDataW-1:0]  prdata,
	output logic                          pready,
	output kbr_pkg::kbr_cfg_t             cfg
);
	import kbr_pkg::*;

	kbr_cfg_t cfg_q;
	kbr_reg_t sel;
	logic     wr_en;

	assign sel    = kbr_reg_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kw_timeout   <= KwTimeoutRst;
			cfg_q.echo_timeout <= EchoTimeoutRst;
			cfg_q.len_timeout  <= LenTimeoutRst;
			cfg_q.byte_timeout <= ByteTimeoutRst;
		end else if (wr_en) begin
			case (sel)
				REG_KW_TIMEOUT:   cfg_q.kw_timeout   <= pwdata[TimeoutW-1:0];
				REG_ECHO_TIMEOUT: cfg_q.echo_timeout <= pwdata[TimeoutW-1:0];
				REG_LEN_TIMEOUT:  cfg_q.len_timeout  <= pwdata[TimeoutW-1:0];
				REG_BYTE_TIMEOUT: cfg_q.byte_timeout <= pwdata[TimeoutW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (sel)
			REG_KW_TIMEOUT:   prdata[TimeoutW-1:0] = cfg_q.kw_timeout;
			REG_ECHO_TIMEOUT: prdata[TimeoutW-1:0] = cfg_q.echo_timeout;
			REG_LEN_TIMEOUT:  prdata[TimeoutW-1:0] = cfg_q.len_timeout;
			REG_BYTE_TIMEOUT: prdata[TimeoutW-1:0] = cfg_q.byte_timeout;
			default: prdata = '0;
		endcase
	end

endmodule

// ===== design/kbr_fsm.sv =====
// protocol sequencer: keyword and block phases, timers and result decode
module kbr_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [1:0]        func,
	input  logic [7:0]        rx_byte,
	input  kbr_pkg::kbr_cfg_t cfg,
	output kbr_pkg::kbr_res_t res
);
	import kbr_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_KW,
		PH_KW_ECHO,
		PH_LEN,
		PH_BYTE,
		PH_ECHO,
		PH_END
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [TimeoutW-1:0] timer_q, timer_d;
	logic [7:0]          echo_q, echo_d;
	logic [7:0]          len_q, len_d;
	logic [7:0]          taken_q, taken_d;
	logic [TimeoutW-1:0] limit;
	logic [7:0]          taken_inc;
	kbr_func_t           fn;

	assign fn        = kbr_func_t'(func);
	assign taken_inc = taken_q + 8'd1;

	always_comb begin
		case (phase_q)
			PH_KW:               limit = cfg.kw_timeout;
			PH_KW_ECHO, PH_ECHO: limit = cfg.echo_timeout;
			PH_LEN, PH_END:      limit = cfg.len_timeout;
			default:             limit = cfg.byte_timeout;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		echo_d  = echo_q;
		len_d   = len_q;
		taken_d = taken_q;
		res     = '0;
		res.byte_index = taken_q;
		res.event_res  = EV_NONE;

		case (fn)
			FUNC_START_KW: begin
				taken_d = '0;
				timer_d = '0;
				phase_d = PH_KW;
			end
			FUNC_START_BLK: begin
				taken_d = '0;
				timer_d = '0;
				phase_d = PH_LEN;
			end
			FUNC_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (timer_q >= limit) begin
						res.present   = 1'b1;
						res.event_res = EV_TIMEOUT;
						phase_d       = PH_IDLE;
						timer_d       = '0;
					end else begin
						timer_d = timer_q + 1'b1;
					end
				end
			end
			default: begin
				// received byte; every failure reports and drops to idle
				case (phase_q)
					PH_KW: begin
						if (taken_q > 8'd2 || rx_byte != kw_expected(taken_q[1:0])) begin
							res.present   = 1'b1;
							res.event_res = EV_KW_BAD;
							phase_d       = PH_IDLE;
							timer_d       = '0;
						end else begin
							taken_d = taken_inc;
							timer_d = '0;
							if (taken_inc == KwCount) begin
								echo_d         = KwAnswer;
								phase_d        = PH_KW_ECHO;
								res.present    = 1'b1;
								res.tx_valid   = 1'b1;
								res.tx_byte    = KwAnswer;
								res.byte_index = taken_inc;
							end
						end
					end
					PH_KW_ECHO: begin
						res.present   = 1'b1;
						res.event_res = (rx_byte != echo_q) ? EV_ECHO : EV_KW_OK;
						phase_d       = PH_IDLE;
						timer_d       = '0;
					end
					PH_LEN, PH_BYTE: begin
						if (phase_q == PH_LEN) begin
							len_d = rx_byte;
						end
						echo_d       = rx_byte ^ ComplMask;
						phase_d      = PH_ECHO;
						timer_d      = '0;
						res.present  = 1'b1;
						res.tx_valid = 1'b1;
						res.tx_byte  = rx_byte ^ ComplMask;
					end
					PH_ECHO: begin
						timer_d = '0;
						if (rx_byte != echo_q) begin
							res.present   = 1'b1;
							res.event_res = EV_ECHO;
							phase_d       = PH_IDLE;
						end else if (taken_q == 8'd0 && len_q < MinBlockLen) begin
							res.present   = 1'b1;
							res.event_res = EV_LENGTH;
							phase_d       = PH_IDLE;
						end else begin
							res.present    = 1'b1;
							res.data_valid = 1'b1;
							res.data_byte  = echo_q ^ ComplMask;
							taken_d        = taken_inc;
							phase_d        = (taken_inc >= len_q) ? PH_END : PH_BYTE;
						end
					end
					PH_END: begin
						res.present   = 1'b1;
						res.event_res = (rx_byte != EndByte) ? EV_END : EV_BLK_OK;
						phase_d       = PH_IDLE;
						timer_d       = '0;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			echo_q  <= '0;
			len_q   <= '0;
			taken_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			echo_q  <= echo_d;
			len_q   <= len_d;
			taken_q <= taken_d;
		end
	end

endmodule

// ===== design/kbr_out_reg.sv =====
// result register between the sequencer and the output channel
module kbr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  kbr_pkg::kbr_res_t res,
	output logic              can_take,
	kbr_out_if.source         res_out
);
	import kbr_pkg::*;

	logic     valid_q;
	kbr_res_t res_q;

	// a waiting result that leaves this cycle frees the slot for the next
	assign can_take = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= res.present;
		end else if (res_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.present) begin
			res_q <= res;
		end
	end

	assign res_out.valid      = valid_q;
	assign res_out.tx_valid   = res_q.tx_valid;
	assign res_out.tx_byte    = res_q.tx_byte;
	assign res_out.data_valid = res_q.data_valid;
	assign res_out.data_byte  = res_q.data_byte;
	assign res_out.byte_index = res_q.byte_index;
	assign res_out.event_res  = 3'(res_q.event_res);

endmodule

// ===== design/kline_block_receiver_unit.sv =====
// top level of the k-line block receiver
//
//  channel   dir  handshake            payload
//  evt_in    in   valid/ready          func, rx_byte
//  res_out   out  valid/ready          tx_valid, tx_byte, data_valid, data_byte,
//                                      byte_index, event_res
//  apb       in   psel/penable, pready timeout registers at 0x0, 0x4, 0x8, 0xc
//
// one event per cycle while no result stalls; a result appears the cycle after its transfer
// the result register lets a new event in while the old result leaves
// a stalled result holds off evt_in until res_out takes it
// reset returns the sequencer to idle and loads the default timeouts
module kline_block_receiver_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	kbr_in_if.sink                        evt_in,
	kbr_out_if.source                     res_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kbr_pkg::ApbAddrW-1:0]  paddr,
	input  logic [kbr_pkg::ApbDataW-1:0]  pwdata,
	output logic [kbr_pkg::ApbDataW-1:0]  prdata,
	output logic                          pready
);
	import kbr_pkg::*;

	kbr_cfg_t cfg;
	kbr_res_t res;
	logic     can_take;
	logic     take;

	assign evt_in.ready = can_take;
	assign take         = evt_in.valid && can_take;

	kbr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kbr_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.func    (evt_in.func),
		.rx_byte (evt_in.rx_byte),
		.cfg     (cfg),
		.res     (res)
	);

	kbr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.res      (res),
		.can_take (can_take),
		.res_out  (res_out)
	);

endmodule

// ===== test/kline_block_receiver_unit_test.sv =====
// self-checking testbench of the k-line block receiver: keyword and block sequences, noise
module kline_block_receiver_unit_test;
	import kbr_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int PhaseItems = 100;
	localparam int PhaseCount = 8;

	typedef enum logic [2:0] {
		LP_IDLE, LP_KW, LP_KW_ECHO, LP_LEN, LP_BYTE, LP_ECHO, LP_END
	} link_phase_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       data_valid;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		kbr_event_t event_res;
	} link_reply_t;

	// tracks the link sequencer and queues the replies it must produce
	class link_tracker;
		logic [TimeoutW-1:0] limits [4];
		link_phase_t         phase;
		logic [TimeoutW-1:0] wait_timer;
		logic [7:0]          echo_due;
		logic [7:0]          block_length;
		logic [7:0]          bytes_taken;
		link_reply_t         replies_due [$];
		int                  used;
		int                  errors;

		function new();
			limits[int'(REG_KW_TIMEOUT)] = KwTimeoutRst;
			limits[int'(REG_ECHO_TIMEOUT)] = EchoTimeoutRst;
			limits[int'(REG_LEN_TIMEOUT)] = LenTimeoutRst;
			limits[int'(REG_BYTE_TIMEOUT)] = ByteTimeoutRst;
			phase = LP_IDLE;
			wait_timer = '0;
			echo_due = '0;
			block_length = '0;
			bytes_taken = '0;
			used = 0;
			errors = 0;
		endfunction

		function void set_limit(kbr_reg_t r, logic [TimeoutW-1:0] v);
			limits[int'(r)] = v;
		endfunction

		function logic [TimeoutW-1:0] limit_now();
			case (phase)
				LP_KW: return limits[int'(REG_KW_TIMEOUT)];
				LP_KW_ECHO, LP_ECHO: return limits[int'(REG_ECHO_TIMEOUT)];
				LP_LEN, LP_END: return limits[int'(REG_LEN_TIMEOUT)];
				default: return limits[int'(REG_BYTE_TIMEOUT)];
			endcase
		endfunction

		function void enter(link_phase_t p);
			phase = p;
			wait_timer = '0;
		endfunction

		function void reply(logic txv, logic [7:0] txb, logic dv, logic [7:0] db,
			kbr_event_t ev);
			link_reply_t r;
			r.tx_valid = txv;
			r.tx_byte = txb;
			r.data_valid = dv;
			r.data_byte = db;
			r.byte_index = bytes_taken;
			r.event_res = ev;
			replies_due.push_back(r);
		endfunction

		function void abandon(kbr_event_t ev);
			reply(1'b0, 8'h00, 1'b0, 8'h00, ev);
			enter(LP_IDLE);
		endfunction

		function logic [7:0] keyword_at(logic [7:0] pos);
			case (pos)
				8'd0: return KwByte0;
				8'd1: return KwByte1;
				default: return KwByte2;
			endcase
		endfunction

		// one accepted event in
		function void note_event(kbr_func_t f, logic [7:0] rx);
			if (f == FUNC_START_KW || f == FUNC_START_BLK) begin
				bytes_taken = '0;
				if (f == FUNC_START_KW) enter(LP_KW);
				else enter(LP_LEN);
				used++;
				return;
			end
			if (phase == LP_IDLE) return;
			used++;
			if (f == FUNC_TICK) begin
				if (wait_timer >= limit_now()) abandon(EV_TIMEOUT);
				else wait_timer = wait_timer + 1'b1;
				return;
			end
			case (phase)
				LP_KW: begin
					if (bytes_taken > 8'd2 || rx != keyword_at(bytes_taken)) begin
						abandon(EV_KW_BAD);
					end else begin
						bytes_taken++;
						if (bytes_taken < KwCount) begin
							enter(LP_KW);
						end else begin
							echo_due = KwAnswer;
							enter(LP_KW_ECHO);
							reply(1'b1, KwAnswer, 1'b0, 8'h00, EV_NONE);
						end
					end
				end
				LP_KW_ECHO: begin
					if (rx != echo_due) abandon(EV_ECHO);
					else abandon(EV_KW_OK);
				end
				LP_LEN, LP_BYTE: begin
					if (phase == LP_LEN) block_length = rx;
					echo_due = rx ^ ComplMask;
					enter(LP_ECHO);
					reply(1'b1, echo_due, 1'b0, 8'h00, EV_NONE);
				end
				LP_ECHO: begin
					if (rx != echo_due) begin
						abandon(EV_ECHO);
					end else if (bytes_taken == 8'd0 && block_length < MinBlockLen) begin
						abandon(EV_LENGTH);
					end else begin
						reply(1'b0, 8'h00, 1'b1, echo_due ^ ComplMask, EV_NONE);
						bytes_taken++;
						if (bytes_taken >= block_length) enter(LP_END);
						else enter(LP_BYTE);
					end
				end
				default: begin
					if (rx != EndByte) abandon(EV_END);
					else abandon(EV_BLK_OK);
				end
			endcase
		endfunction

		function void field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s expected %0h got %0h", name, want, got);
				errors++;
			end
		endfunction

		// one accepted result out
		function void check_result(logic txv, logic [7:0] txb, logic dv, logic [7:0] db,
			logic [7:0] idx, logic [2:0] ev);
			link_reply_t w;
			if (replies_due.size() == 0) begin
				$error("unexpected result: event_res expected none got %0d", ev);
				errors++;
				return;
			end
			w = replies_due.pop_front();
			field("tx_valid", 8'(w.tx_valid), 8'(txv));
			field("tx_byte", w.tx_byte, txb);
			field("data_valid", 8'(w.data_valid), 8'(dv));
			field("data_byte", w.data_byte, db);
			field("byte_index", w.byte_index, idx);
			field("event_res", 8'(w.event_res), 8'(ev));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	kbr_in_if  evt_in ();
	kbr_out_if res_out ();

	kline_block_receiver_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt_in  (evt_in),
		.res_out (res_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	link_tracker tracker = new();
	bit          send_calm;
	bit          sink_calm;
	int          cycles = 0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL kline_block_receiver_unit");
			$finish;
		end
	end

	function automatic int pause_len(bit calm);
		if (calm) return 0;
		return $urandom_range(0, 12);
	endfunction

	// result side: random stalls, check every transfer
	initial begin : result_sink
		int hold;
		hold = 0;
		res_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_out.ready = (hold == 0);
			if (hold > 0) hold--;
			@(posedge clk);
			if (res_out.ready && res_out.valid) begin
				tracker.check_result(res_out.tx_valid, res_out.tx_byte, res_out.data_valid,
					res_out.data_byte, res_out.byte_index, res_out.event_res);
				hold = pause_len(sink_calm);
			end
		end
	end

	task automatic send_event(input kbr_func_t f, input logic [7:0] b);
		int gap;
		bit taken;
		gap = pause_len(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			evt_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_in.valid = 1'b1;
		evt_in.func = f;
		evt_in.rx_byte = b;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = evt_in.ready;
		end
		tracker.note_event(f, b);
	endtask

	task automatic settle();
		@(negedge clk);
		evt_in.valid = 1'b0;
		while (tracker.replies_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_write(input kbr_reg_t r, input logic [TimeoutW-1:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {r, 2'b00};
		pwdata = $urandom;
		pwdata[TimeoutW-1:0] = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		tracker.set_limit(r, v);
	endtask

	task automatic load_limits(input int kind);
		logic [TimeoutW-1:0] v;
		for (int i = 0; i < 4; i++) begin
			case (kind % 4)
				0: v = '0;
				1: v = '1;
				default: begin
					if ($urandom_range(0, 5) == 0) v = TimeoutW'($urandom_range(0, 1023));
					else v = TimeoutW'($urandom_range(0, 6));
				end
			endcase
			apb_write(kbr_reg_t'(i), v);
		end
	endtask

	// sometimes ticks, around the current timeout when it is small, then the awaited byte, sometimes spoiled
	task automatic offer(input logic [7:0] b);
		int n;
		int lim;
		if (tracker.phase == LP_IDLE) return;
		if ($urandom_range(0, 3) == 0) begin
			lim = int'(tracker.limit_now());
			if (lim <= 6) n = $urandom_range(0, lim + 1);
			else n = $urandom_range(1, 4);
			for (int i = 0; i < n && tracker.phase != LP_IDLE; i++)
				send_event(FUNC_TICK, 8'($urandom_range(0, 255)));
		end
		if (tracker.phase == LP_IDLE) return;
		if ($urandom_range(0, 29) == 0) b = 8'($urandom_range(0, 255));
		send_event(FUNC_RX_BYTE, b);
	endtask

	task automatic keyword_try();
		send_event(FUNC_START_KW, 8'($urandom_range(0, 255)));
		offer(KwByte0);
		offer(KwByte1);
		offer(KwByte2);
		offer(KwAnswer);
	endtask

	task automatic block_try();
		logic [7:0] len;
		logic [7:0] d;
		int pick;
		pick = $urandom_range(0, 39);
		if (pick == 0) len = 8'($urandom_range(100, 255));
		else if (pick <= 6) len = 8'($urandom_range(0, 2));
		else len = 8'($urandom_range(3, 12));
		send_event(FUNC_START_BLK, 8'($urandom_range(0, 255)));
		offer(len);
		offer(~len);
		for (int i = 1; i < int'(len) && tracker.phase != LP_IDLE; i++) begin
			d = 8'($urandom_range(0, 255));
			offer(d);
			offer(~d);
		end
		if ($urandom_range(0, 7) == 0) offer(8'($urandom_range(0, 255)));
		else offer(EndByte);
	endtask

	initial begin : stimulus
		int target;
		int pick;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		evt_in.valid = 1'b0;
		evt_in.func = FUNC_RX_BYTE;
		evt_in.rx_byte = 8'h00;
		send_calm = 1'b0;
		sink_calm = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idle ignores bytes and ticks
		send_event(FUNC_RX_BYTE, 8'hFF);
		send_event(FUNC_TICK, 8'h00);
		// good keyword
		send_event(FUNC_START_KW, 8'h00);
		send_event(FUNC_RX_BYTE, KwByte0);
		send_event(FUNC_RX_BYTE, KwByte1);
		send_event(FUNC_RX_BYTE, KwByte2);
		send_event(FUNC_RX_BYTE, KwAnswer);
		// wrong keyword byte, then wrong echo of the keyword answer
		send_event(FUNC_START_KW, 8'hFF);
		send_event(FUNC_RX_BYTE, KwByte0);
		send_event(FUNC_RX_BYTE, 8'h02);
		send_event(FUNC_START_KW, 8'h00);
		send_event(FUNC_RX_BYTE, KwByte0);
		send_event(FUNC_RX_BYTE, KwByte1);
		send_event(FUNC_RX_BYTE, KwByte2);
		send_event(FUNC_RX_BYTE, 8'h74);
		// short length, answered then refused
		send_event(FUNC_START_BLK, 8'h00);
		send_event(FUNC_RX_BYTE, 8'h02);
		send_event(FUNC_RX_BYTE, 8'hFD);
		// longest length, aborted by a start command
		send_event(FUNC_START_BLK, 8'h00);
		send_event(FUNC_RX_BYTE, 8'hFF);
		send_event(FUNC_RX_BYTE, 8'h00);
		// minimal block with extreme data bytes
		send_event(FUNC_START_BLK, 8'h00);
		send_event(FUNC_RX_BYTE, 8'h03);
		send_event(FUNC_RX_BYTE, 8'hFC);
		send_event(FUNC_RX_BYTE, 8'h00);
		send_event(FUNC_RX_BYTE, 8'hFF);
		send_event(FUNC_RX_BYTE, 8'hFF);
		send_event(FUNC_RX_BYTE, 8'h00);
		send_event(FUNC_RX_BYTE, EndByte);
		settle();

		for (int p = 0; p < PhaseCount; p++) begin
			load_limits(p);
			target = tracker.used + PhaseItems;
			while (tracker.used < target) begin
				send_calm = ($urandom_range(0, 4) == 0);
				sink_calm = ($urandom_range(0, 4) == 0);
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					repeat ($urandom_range(1, 4))
						send_event(kbr_func_t'($urandom_range(0, 3)),
							8'($urandom_range(0, 255)));
				end else if (pick <= 3) begin
					keyword_try();
				end else begin
					block_try();
				end
			end
			settle();
		end

		if (tracker.errors == 0) begin
			$display("PASS kline_block_receiver_unit");
		end else begin
			$display("FAIL kline_block_receiver_unit");
		end
		$finish;
	end

endmodule
